@@ sv/fat32_cluster_chain_reader_defines.svh @@
// ----------------------------------------------------------------------------
// FAT32 cluster chain reader assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FAT32_CLUSTER_CHAIN_READER_DEFINES_SVH
`define FAT32_CLUSTER_CHAIN_READER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FCCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fccr check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FCCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fccr check failed");

`endif

@@ sv/fccr_pkg.sv @@
// ----------------------------------------------------------------------------
// FAT32 cluster chain reader package
// Shared types, codes and constants of the chain reader.
// ----------------------------------------------------------------------------
`default_nettype none

package fccr_pkg;

  localparam int unsigned SECTOR_BYTES        = 512;
  localparam int unsigned MAX_CLUSTER_SECTORS = 32;
  localparam int unsigned ENTRY_BYTES         = 4;
  localparam int unsigned ENTRY_SHIFT         = $clog2(SECTOR_BYTES / ENTRY_BYTES);

  localparam int unsigned CS_W      = 6;
  localparam int unsigned LBA_W     = 32;
  localparam int unsigned CLUSTER_W = 28;
  localparam int unsigned FAT_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CLUSTER_W-1:0] CHAIN_END   = 28'h FFFFFF8;
  localparam logic [CLUSTER_W-1:0] BAD_CLUSTER = 28'h FFFFFF7;

  localparam logic [LBA_W-1:0] DATA_LBA_RESET  = 32'd0;
  localparam logic [CS_W-1:0]  CS_RESET        = 6'd1;
  localparam logic [FAT_W-1:0] FAT_LBA_RESET   = 16'd32;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_REPLY = 2'd1,
    OP_ABORT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FAT  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_ERROR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_DATA_LBA        = 2'd0,
    CFG_CLUSTER_SECTORS = 2'd1,
    CFG_FAT_LBA         = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_WAIT = 3'd1,
    ST_MUL  = 3'd2,
    ST_BASE = 3'd3,
    ST_DATA = 3'd4,
    ST_FAT  = 3'd5,
    ST_DONE = 3'd6
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] cluster_value;
    logic [31:0] file_bytes;
    logic        read_error;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sector_lba;
    logic [8:0]  entry_offset;
    logic [9:0]  valid_bytes;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load_start;
    logic    load_reply;
    logic    mul;
    logic    base;
    logic    emit;
    kind_e   emit_kind;
    status_e done_status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       out_ready;
    logic [1:0] op;
    logic       in_rerr;
    logic       in_size_zero;
    logic       in_end;
    logic       in_bad;
    logic       last_chunk;
    logic       last_sector;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/fccr_ctrl.sv @@
// ----------------------------------------------------------------------------
// FAT32 cluster chain reader controller
// Sequences start, multiply, base, data reads, FAT read and done.
// ----------------------------------------------------------------------------
`default_nettype none

module fccr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire fccr_pkg::sts_t  sts_i,
  output fccr_pkg::cmd_t       cmd_o,
  output fccr_pkg::state_e     state_o
);

  fccr_pkg::state_e  state_q, state_d;
  fccr_pkg::status_e status_q, status_d;
  logic              in_ready;
  logic              accept;

  assign in_ready   = (state_q == fccr_pkg::ST_IDLE) || (state_q == fccr_pkg::ST_WAIT);
  assign accept     = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;
  assign state_o    = state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fccr_pkg::ST_IDLE;
      status_q <= fccr_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // Next state.
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      fccr_pkg::ST_IDLE, fccr_pkg::ST_WAIT: begin
        if (accept) begin
          unique case (sts_i.op)
            fccr_pkg::OP_START: begin
              if (sts_i.in_size_zero) begin
                state_d  = fccr_pkg::ST_DONE;
                status_d = fccr_pkg::STAT_OK;
              end else if (sts_i.in_end) begin
                state_d  = fccr_pkg::ST_DONE;
                status_d = fccr_pkg::STAT_SHORT;
              end else begin
                state_d = fccr_pkg::ST_MUL;
              end
            end
            fccr_pkg::OP_REPLY: begin
              if (state_q == fccr_pkg::ST_WAIT) begin
                if (sts_i.in_rerr || sts_i.in_bad) begin
                  state_d  = fccr_pkg::ST_DONE;
                  status_d = fccr_pkg::STAT_ERROR;
                end else if (sts_i.in_end) begin
                  state_d  = fccr_pkg::ST_DONE;
                  status_d = fccr_pkg::STAT_SHORT;
                end else begin
                  state_d = fccr_pkg::ST_MUL;
                end
              end
            end
            fccr_pkg::OP_ABORT: begin
              if (state_q == fccr_pkg::ST_WAIT) begin
                state_d  = fccr_pkg::ST_DONE;
                status_d = fccr_pkg::STAT_ERROR;
              end
            end
            default: begin
              state_d = state_q;
            end
          endcase
        end
      end
      fccr_pkg::ST_MUL:  state_d = fccr_pkg::ST_BASE;
      fccr_pkg::ST_BASE: state_d = fccr_pkg::ST_DATA;
      fccr_pkg::ST_DATA: begin
        if (sts_i.out_ready) begin
          if (sts_i.last_chunk) begin
            state_d  = fccr_pkg::ST_DONE;
            status_d = fccr_pkg::STAT_OK;
          end else if (sts_i.last_sector) begin
            state_d = fccr_pkg::ST_FAT;
          end
        end
      end
      fccr_pkg::ST_FAT: begin
        if (sts_i.out_ready) state_d = fccr_pkg::ST_WAIT;
      end
      fccr_pkg::ST_DONE: begin
        if (sts_i.out_ready) state_d = fccr_pkg::ST_IDLE;
      end
      default: state_d = fccr_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_kind   = fccr_pkg::KIND_DATA;
    cmd_o.done_status = status_q;
    unique case (state_q)
      fccr_pkg::ST_IDLE, fccr_pkg::ST_WAIT: begin
        cmd_o.load_start = accept && (sts_i.op == fccr_pkg::OP_START);
        cmd_o.load_reply = accept && (sts_i.op == fccr_pkg::OP_REPLY)
                           && (state_q == fccr_pkg::ST_WAIT);
      end
      fccr_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      fccr_pkg::ST_BASE: cmd_o.base = 1'b1;
      fccr_pkg::ST_DATA: begin
        cmd_o.emit      = sts_i.out_ready;
        cmd_o.emit_kind = fccr_pkg::KIND_DATA;
      end
      fccr_pkg::ST_FAT: begin
        cmd_o.emit      = sts_i.out_ready;
        cmd_o.emit_kind = fccr_pkg::KIND_FAT;
      end
      fccr_pkg::ST_DONE: begin
        cmd_o.emit      = sts_i.out_ready;
        cmd_o.emit_kind = fccr_pkg::KIND_DONE;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/fccr_dpath.sv @@
// ----------------------------------------------------------------------------
// FAT32 cluster chain reader datapath
// Configuration registers, chain state, LBA arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fccr_dpath #(
  parameter int unsigned MaxClusterSectors = fccr_pkg::MAX_CLUSTER_SECTORS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fccr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire fccr_pkg::in_t                 in_data_i,
  input  wire fccr_pkg::cmd_t                cmd_i,
  output fccr_pkg::sts_t                     sts_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output fccr_pkg::out_t                     out_data_o
);

  localparam int unsigned SecW = (MaxClusterSectors > 1) ? $clog2(MaxClusterSectors) : 1;
  localparam int unsigned CsW  = fccr_pkg::CS_W;

  logic [31:0]                     data_lba_q;
  logic [CsW-1:0]                  cs_q;
  logic [fccr_pkg::FAT_W-1:0]      fat_lba_q;
  logic [fccr_pkg::CLUSTER_W-1:0]  cluster_q;
  logic [31:0]                     bytes_q;
  logic [31:0]                     prod_q;
  logic [31:0]                     lba_q;
  logic [SecW-1:0]                 sec_q;
  logic                            out_valid_q;
  fccr_pkg::out_t                  out_q;

  logic [CsW-1:0]                  spc;
  logic [fccr_pkg::CLUSTER_W-1:0]  in_cluster;
  logic [31:0]                     clus_m2;
  logic [37:0]                     prod_full;
  logic [9:0]                      chunk;
  logic                            out_ready;
  logic                            emit_data;
  logic [31:0]                     fat_lba;
  logic [8:0]                      entry_off;
  fccr_pkg::out_t                  out_d;

  // Effective sectors per cluster: zero acts as one, saturate at the maximum.
  always_comb begin
    if (cs_q == '0) begin
      spc = CsW'(1);
    end else if (cs_q > CsW'(MaxClusterSectors)) begin
      spc = CsW'(MaxClusterSectors);
    end else begin
      spc = cs_q;
    end
  end

  assign in_cluster = in_data_i.cluster_value[fccr_pkg::CLUSTER_W-1:0];
  assign clus_m2    = {4'b0000, cluster_q} - 32'd2;
  assign prod_full  = 38'(clus_m2) * 38'(spc);
  assign chunk      = (bytes_q < 32'(fccr_pkg::SECTOR_BYTES)) ? bytes_q[9:0]
                                                              : 10'(fccr_pkg::SECTOR_BYTES);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign emit_data  = cmd_i.emit && (cmd_i.emit_kind == fccr_pkg::KIND_DATA);
  assign fat_lba    = 32'(fat_lba_q) + 32'(cluster_q >> fccr_pkg::ENTRY_SHIFT);
  assign entry_off  = 9'({cluster_q[fccr_pkg::ENTRY_SHIFT-1:0], 2'b00});

  always_comb begin
    sts_o              = '0;
    sts_o.out_ready    = out_ready;
    sts_o.op           = in_data_i.op;
    sts_o.in_rerr      = in_data_i.read_error;
    sts_o.in_size_zero = (in_data_i.file_bytes == '0);
    sts_o.in_end       = (in_cluster >= fccr_pkg::CHAIN_END);
    sts_o.in_bad       = (in_cluster == fccr_pkg::BAD_CLUSTER);
    sts_o.last_chunk   = (bytes_q <= 32'(fccr_pkg::SECTOR_BYTES));
    sts_o.last_sector  = (CsW'(sec_q) == (spc - CsW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_lba_q <= fccr_pkg::DATA_LBA_RESET;
      cs_q       <= fccr_pkg::CS_RESET;
      fat_lba_q  <= fccr_pkg::FAT_LBA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fccr_pkg::CFG_DATA_LBA:        data_lba_q <= cfg_data_i;
        fccr_pkg::CFG_CLUSTER_SECTORS: cs_q       <= cfg_data_i[CsW-1:0];
        fccr_pkg::CFG_FAT_LBA:         fat_lba_q  <= cfg_data_i[fccr_pkg::FAT_W-1:0];
        default:                       data_lba_q <= data_lba_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      cluster_q <= in_cluster;
      bytes_q   <= in_data_i.file_bytes;
    end else if (cmd_i.load_reply) begin
      cluster_q <= in_cluster;
    end else if (emit_data) begin
      bytes_q <= bytes_q - 32'(chunk);
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[31:0];
    end
    if (cmd_i.base) begin
      lba_q <= data_lba_q + prod_q;
      sec_q <= '0;
    end else if (emit_data) begin
      lba_q <= lba_q + 32'd1;
      sec_q <= sec_q + SecW'(1);
    end
  end

  // Assemble the result for the current emit.
  always_comb begin
    out_d      = '0;
    out_d.kind = cmd_i.emit_kind;
    unique case (cmd_i.emit_kind)
      fccr_pkg::KIND_DATA: begin
        out_d.sector_lba  = lba_q;
        out_d.valid_bytes = chunk;
      end
      fccr_pkg::KIND_FAT: begin
        out_d.sector_lba   = fat_lba;
        out_d.entry_offset = entry_off;
        out_d.last         = 1'b1;
      end
      fccr_pkg::KIND_DONE: begin
        out_d.status = cmd_i.done_status;
        out_d.last   = 1'b1;
      end
      default: out_d.last = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ sv/fat32_cluster_chain_reader.sv @@
// ----------------------------------------------------------------------------
// FAT32 cluster chain reader
// Walks a file's cluster chain and issues data and FAT sector read requests.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_data_i): start a file (op 0),
//     return a FAT entry (op 1) or abort after a data read error (op 2).
//     A transaction is taken only while the block is idle or waits for a
//     FAT entry; a reply or an abort taken while idle, and op 3, is dropped.
//   out channel (out_valid_o / out_stall_i / out_data_o): data sector
//     reads, one FAT sector read per cluster while bytes remain, and a
//     done transaction with the status. Every run ends with last = 1.
//   cfg channel (cfg_valid_i / cfg_ready_o): always ready; write only idle.
// Sequence: per cluster, the multiply state and then the base (add) state
//   compute the base LBA, then one result leaves per cycle while the
//   receiver does not stall: up to sectors-per-cluster data reads and
//   one FAT read. Start and reply items that end the run pass through
//   the done state into the output register.
// A stalled receiver holds the output register and freezes the sequencer.
// Reset idles the sequencer, clears the output valid and loads the
// register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat32_cluster_chain_reader_defines.svh"

module fat32_cluster_chain_reader #(
  parameter int unsigned MaxClusterSectors = fccr_pkg::MAX_CLUSTER_SECTORS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fccr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire fccr_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output fccr_pkg::out_t                      out_data_o
);

  fccr_pkg::cmd_t   cmd;
  fccr_pkg::sts_t   sts;
  fccr_pkg::state_e state;

  // Configuration never back-pressures.
  assign cfg_ready_o = 1'b1;

  fccr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  fccr_dpath #(
    .MaxClusterSectors (MaxClusterSectors)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Input transactions land only while idle or waiting for a FAT entry.
  `FCCR_ASSERT_SAME(a_accept_state, in_valid_i && !in_stall_o,
                    (state == fccr_pkg::ST_IDLE) || (state == fccr_pkg::ST_WAIT))
  // Never overwrite a result the receiver has not taken.
  `FCCR_ASSERT_SAME(a_emit_ready, cmd.emit, sts.out_ready)
  // Data reads carry file bytes and never close a run.
  `FCCR_ASSERT_SAME(a_data_shape, out_valid_o && (out_data_o.kind == fccr_pkg::KIND_DATA),
                    !out_data_o.last && (out_data_o.valid_bytes != '0))
  // A FAT read always leaves the sequencer waiting for the reply.
  `FCCR_ASSERT_NEXT(a_fat_wait, cmd.emit && (cmd.emit_kind == fccr_pkg::KIND_FAT),
                    state == fccr_pkg::ST_WAIT)

endmodule

`default_nettype wire

@@ tb/fat32_cluster_chain_reader_tb.sv @@
// ----------------------------------------------------------------------------
// FAT32 cluster chain reader testbench
// Drives start, FAT reply and abort transactions into the chain reader and
// checks every data-sector, FAT-sector and done request it issues against a
// cycle-free predictor of the chain walk. Directed cases come first, then
// random chains under several register settings, random idling on both
// channels and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module fat32_cluster_chain_reader_tb;
  import fccr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Long enough for a full 32-sector cluster, plus slack.
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_SHOWN     = 10;

  // Codes the package leaves unnamed.
  localparam logic [1:0]           OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;

  // Register copies and chain walk state of the predictor.
  logic [31:0]          shadow_data_lba;
  logic [CS_W-1:0]      shadow_spc;
  logic [FAT_W-1:0]     shadow_fat_lba;
  logic                 chain_waiting;
  logic [CLUSTER_W-1:0] chain_cluster;
  logic [31:0]          chain_bytes_left;

  // Requests the block still owes us, oldest first.
  out_t pending_reqs[$];

  // Idling and back-pressure controls.
  bit          in_idle_on;
  bit          out_idle_on;
  int unsigned out_burst;
  int          hold_left;

  // Bookkeeping.
  int unsigned cycle_cnt;
  int unsigned items_sent;
  int unsigned live_items;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned configs_applied;

  fat32_cluster_chain_reader u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor of the chain walk
  // --------------------------------------------------------------------------

  // Zero reads as one, anything above the maximum saturates.
  function automatic int unsigned cluster_span();
    if (shadow_spc == 0) return 1;
    if (shadow_spc > MAX_CLUSTER_SECTORS) return MAX_CLUSTER_SECTORS;
    return shadow_spc;
  endfunction

  function automatic void queue_req(kind_e kind, logic [31:0] lba, logic [8:0] offset,
                                    logic [9:0] nbytes, status_e status);
    out_t req;
    req.kind         = kind;
    req.sector_lba   = lba;
    req.entry_offset = offset;
    req.valid_bytes  = nbytes;
    req.status       = status;
    req.last         = 1'b0;
    pending_reqs.push_back(req);
  endfunction

  function automatic void end_chain(status_e status);
    queue_req(KIND_DONE, '0, '0, '0, status);
    chain_waiting = 1'b0;
  endfunction

  // Data reads of the current cluster, then either its FAT read or done.
  function automatic void walk_cluster();
    int unsigned spc;
    logic [31:0] base;
    logic [31:0] chunk;
    spc  = cluster_span();
    base = shadow_data_lba + (32'(chain_cluster) - 32'd2) * spc;
    for (int unsigned i = 0; i < spc && chain_bytes_left != 0; i++) begin
      chunk = (chain_bytes_left < SECTOR_BYTES) ? chain_bytes_left : SECTOR_BYTES;
      queue_req(KIND_DATA, base + i, '0, chunk[9:0], STAT_OK);
      chain_bytes_left -= chunk;
    end
    if (chain_bytes_left == 0) begin
      // file ends inside this cluster: no trailing FAT read
      end_chain(STAT_OK);
    end else begin
      queue_req(KIND_FAT, 32'(shadow_fat_lba) + 32'(chain_cluster >> ENTRY_SHIFT),
                9'(chain_cluster[ENTRY_SHIFT-1:0] * ENTRY_BYTES), '0, STAT_OK);
      chain_waiting = 1'b1;
    end
  endfunction

  // Advance the walk by one accepted transaction; return the requests it owes.
  function automatic int unsigned predict_requests(in_t item);
    int unsigned          first;
    logic [CLUSTER_W-1:0] next;
    out_t                 tail;
    first = pending_reqs.size();
    case (item.op)
      OP_START: begin
        chain_cluster    = item.cluster_value[CLUSTER_W-1:0];
        chain_bytes_left = item.file_bytes;
        if (item.file_bytes == 0) end_chain(STAT_OK);
        else if (chain_cluster >= CHAIN_END) end_chain(STAT_SHORT);
        else walk_cluster();
      end
      OP_REPLY: begin
        next = item.cluster_value[CLUSTER_W-1:0];
        if (!chain_waiting) begin
          // stray reply, dropped
        end else if (item.read_error || next == BAD_CLUSTER) begin
          end_chain(STAT_ERROR);
        end else if (next >= CHAIN_END) begin
          end_chain(STAT_SHORT);
        end else begin
          chain_cluster = next;
          walk_cluster();
        end
      end
      OP_ABORT: begin
        if (chain_waiting) end_chain(STAT_ERROR);
      end
      default: begin
      end
    endcase
    if (pending_reqs.size() > first) begin
      tail      = pending_reqs.pop_back();
      tail.last = 1'b1;
      pending_reqs.push_back(tail);
    end
    return pending_reqs.size() - first;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic in_t mk_item(logic [1:0] op, logic [31:0] cluster_value,
                                  logic [31:0] file_bytes, logic read_error);
    in_t item;
    item.op            = op;
    item.cluster_value = cluster_value;
    item.file_bytes    = file_bytes;
    item.read_error    = read_error;
    return item;
  endfunction

  // Any end-of-chain marker, with random bits above the 28-bit entry.
  function automatic logic [31:0] chain_end_word();
    return {4'($urandom), CHAIN_END + 28'($urandom_range(0, 7))};
  endfunction

  // Random upper bits on a register word; the block keeps only the low ones.
  function automatic logic [31:0] with_junk(logic [31:0] value, int unsigned width);
    return (32'($urandom) << width) | value;
  endfunction

  function automatic in_t random_start();
    int unsigned r;
    int unsigned cbytes;
    logic [31:0] cluster;
    logic [31:0] size;
    cbytes = cluster_span() * SECTOR_BYTES;
    r = $urandom_range(0, 99);
    if (r < 85) cluster = $urandom;
    else if (r < 91) cluster = $urandom_range(0, 3);
    else cluster = chain_end_word();
    r = $urandom_range(0, 99);
    if (r < 30) size = $urandom_range(1, 3 * cbytes);
    else if (r < 48) size = cbytes * $urandom_range(1, 3);
    else if (r < 60) size = $urandom_range(1, SECTOR_BYTES);
    else if (r < 85) size = $urandom;
    else if (r < 92) size = 32'd0;
    else size = 32'hFFFF_FFFF;
    return mk_item(OP_START, cluster, size, 1'($urandom));
  endfunction

  // Mostly well-formed chains: replies while a FAT entry is awaited, starts
  // while idle, with some broken sequences and noise mixed in.
  function automatic in_t next_random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (chain_waiting) begin
      if (r < 70)
        return mk_item(OP_REPLY, {4'($urandom), 28'($urandom_range(2, 32'h0FFF_FFF6))},
                       $urandom, 1'b0);
      if (r < 78) return mk_item(OP_REPLY, chain_end_word(), $urandom, 1'b0);
      if (r < 83) return mk_item(OP_REPLY, {4'($urandom), BAD_CLUSTER}, $urandom, 1'b0);
      if (r < 88) return mk_item(OP_REPLY, $urandom, $urandom, 1'b1);
      if (r < 93) return mk_item(OP_ABORT, $urandom, $urandom, 1'($urandom));
      if (r < 97) return random_start();
      return mk_item(OP_UNUSED, $urandom, $urandom, 1'($urandom));
    end
    if (r < 82) return random_start();
    if (r < 88) return mk_item(OP_REPLY, $urandom, $urandom, 1'($urandom));
    if (r < 94) return mk_item(OP_ABORT, $urandom, $urandom, 1'($urandom));
    return mk_item(OP_UNUSED, $urandom, $urandom, 1'($urandom));
  endfunction

  // One input transaction. Entered and left at a falling edge; valid stays
  // high on exit so back-to-back items follow without a gap.
  task automatic send_item(in_t item);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_requests(item) != 0) live_items++;
    @(negedge clk);
  endtask

  // Random traffic until n more transactions have had an effect.
  task automatic run_live(int unsigned n);
    int unsigned goal;
    goal = live_items + n;
    while (live_items < goal) send_item(next_random_item());
  endtask

  // Bring the block to idle: close an open chain, drain, let it go quiet.
  task automatic settle();
    if (chain_waiting) send_item(mk_item(OP_ABORT, $urandom, $urandom, 1'($urandom)));
    in_valid <= 1'b0;
    while (pending_reqs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write; valid is left high for a following write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_DATA_LBA:        shadow_data_lba = value;
      CFG_CLUSTER_SECTORS: shadow_spc      = value[CS_W-1:0];
      CFG_FAT_LBA:         shadow_fat_lba  = value[FAT_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // Write every register, plus the unused index, which must change nothing.
  task automatic apply_config(logic [31:0] data_lba, logic [31:0] spc_word,
                              logic [31:0] fat_word);
    write_reg(CFG_DATA_LBA, data_lba);
    write_reg(CFG_CLUSTER_SECTORS, spc_word);
    write_reg(CFG_FAT_LBA, fat_word);
    write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    configs_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: cluster 2 at LBA 0, one sector per cluster, FAT at 32.
  task automatic test_reset_config();
    send_item(mk_item(OP_START, 32'd2, 32'd1000, 1'b0));
    send_item(mk_item(OP_REPLY, 32'd3, 32'd0, 1'b0));
    settle();
  endtask

  task automatic test_special_cases();
    apply_config(32'h0000_1000, 32'd4, 32'd32);
    send_item(mk_item(OP_START, 32'd77, 32'd0, 1'b1));                  // empty file
    send_item(mk_item(OP_START, 32'hFFFF_FFF8, 32'd100, 1'b0));          // marker at start
    send_item(mk_item(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_item(mk_item(OP_START, 32'd0, 32'd2048, 1'b0));                // wraps, exact fill
    send_item(mk_item(OP_START, 32'd1, 32'd5000, 1'b0));                // wraps, FAT read
    send_item(mk_item(OP_REPLY, 32'h0FFF_FFF8, 32'hFFFF_FFFF, 1'b0));    // marker in reply
    send_item(mk_item(OP_START, 32'd5, 32'hFFFF_FFFF, 1'b0));
    send_item(mk_item(OP_REPLY, 32'hF000_007F, 32'd0, 1'b0));            // top bits masked
    send_item(mk_item(OP_REPLY, 32'h0FFF_FFF7, 32'd0, 1'b0));            // bad cluster
    send_item(mk_item(OP_START, 32'h0FFF_FFF6, 32'd3000, 1'b0));
    send_item(mk_item(OP_REPLY, 32'd9, 32'd0, 1'b1));                   // FAT read failed
    send_item(mk_item(OP_START, 32'h0000_0080, 32'd4096, 1'b0));
    send_item(mk_item(OP_ABORT, 32'd0, 32'd0, 1'b0));                   // abort while waiting
    send_item(mk_item(OP_ABORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));    // abort while idle
    send_item(mk_item(OP_REPLY, 32'd12, 32'd0, 1'b0));                  // stray reply
    send_item(mk_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));   // unused op, idle
    send_item(mk_item(OP_START, 32'd10, 32'd3000, 1'b0));
    send_item(mk_item(OP_UNUSED, 32'd11, 32'd0, 1'b0));                 // unused op, waiting
    send_item(mk_item(OP_START, 32'd20, 32'd1, 1'b0));                  // restart
    send_item(mk_item(OP_START, 32'd30, 32'd2049, 1'b0));
    send_item(mk_item(OP_REPLY, 32'hFFFF_FFFF, 32'd0, 1'b0));
    send_item(mk_item(OP_START, 32'd2, 32'd513, 1'b0));                 // partial sector
    settle();
  endtask

  // Register extremes, out-of-range sector counts and junk above each field.
  task automatic test_config_extremes();
    apply_config(32'hFFFF_FFFF, with_junk(MAX_CLUSTER_SECTORS, CS_W), 32'hFFFF_FFFF);
    run_live(10);
    settle();
    apply_config(32'h0000_0000, with_junk(0, CS_W), 32'hFFFF_0000);
    run_live(10);
    settle();
    apply_config($urandom, with_junk(63, CS_W), $urandom);
    run_live(10);
    settle();
    apply_config($urandom, with_junk($urandom_range(33, 62), CS_W), $urandom);
    run_live(10);
    settle();
    apply_config($urandom, with_junk(1, CS_W), $urandom);
    run_live(10);
    settle();
  endtask

  // Hold the output off long enough that the block fills and stalls its input,
  // while the sender keeps offering long chains.
  task automatic test_backpressure();
    apply_config($urandom, with_junk(MAX_CLUSTER_SECTORS, CS_W), $urandom);
    @(posedge clk);
    hold_left <= HOLD_CYCLES;
    @(negedge clk);
    repeat (8) begin
      if (chain_waiting)
        send_item(mk_item(OP_REPLY, {4'($urandom), 28'($urandom_range(2, 32'h0FFF_FFF6))},
                          $urandom, 1'b0));
      else
        send_item(mk_item(OP_START, $urandom_range(2, 32'h00FF_FFFF), 32'hFFFF_FFFF, 1'b0));
    end
    settle();
  endtask

  // Random chains over a few settings; the last phase runs with no idling.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      apply_config($urandom,
                   with_junk((phase == 2) ? MAX_CLUSTER_SECTORS : $urandom_range(1, 8), CS_W),
                   $urandom);
      run_live(20);
      settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall bursts plus the long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_burst != 0) out_burst--;
    else if (out_idle_on && $urandom_range(0, 4) == 0) out_burst = $urandom_range(1, 8);
    out_stall <= (hold_left > 0) || (out_burst != 0);
  end

  // Count the hold-off down, one cycle at a time.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Compare each accepted request with the oldest one owed.
  always @(posedge clk) begin : check_requests
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_reqs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR: unexpected request kind %0d lba %h off %0d bytes %0d st %0d last %0d",
                   out_data.kind, out_data.sector_lba, out_data.entry_offset,
                   out_data.valid_bytes, out_data.status, out_data.last);
      end else begin
        want = pending_reqs.pop_front();
        if (out_data.kind !== want.kind || out_data.sector_lba !== want.sector_lba ||
            out_data.entry_offset !== want.entry_offset ||
            out_data.valid_bytes !== want.valid_bytes ||
            out_data.status !== want.status || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("ERROR: request %0d mismatch", results_seen);
            $display("  expected kind %0d lba %h off %0d bytes %0d st %0d last %0d",
                     want.kind, want.sector_lba, want.entry_offset, want.valid_bytes,
                     want.status, want.last);
            $display("  actual   kind %0d lba %h off %0d bytes %0d st %0d last %0d",
                     out_data.kind, out_data.sector_lba, out_data.entry_offset,
                     out_data.valid_bytes, out_data.status, out_data.last);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d requests still owed",
               cycle_cnt, pending_reqs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    out_stall = 1'b0;
    out_burst = 0;
    hold_left = 0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    cycle_cnt = 0;
    items_sent = 0;
    live_items = 0;
    results_seen = 0;
    mismatches = 0;
    configs_applied = 0;
    shadow_data_lba  = DATA_LBA_RESET;
    shadow_spc       = CS_RESET;
    shadow_fat_lba   = FAT_LBA_RESET;
    chain_waiting    = 1'b0;
    chain_cluster    = '0;
    chain_bytes_left = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_config();
    test_special_cases();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    // settle() already drained; give stray late requests a chance to show up
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d requests from %0d input transactions (%0d dropped by the block).",
             results_seen, items_sent, items_sent - live_items);
    $display("Covered %0d register settings, a %0d-cycle output hold-off and all chain endings.",
             configs_applied, HOLD_CYCLES);
    if (mismatches == 0 && pending_reqs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
